@@ rtl/core/prcq_pkg.sv @@
// shared widths, codes and types of the priority class round-robin queue
package prcq_pkg;

   // beat field widths
   localparam int PRIO_W   = 10;
   localparam int HANDLE_W = 16;
   localparam int STATUS_W = 2;
   localparam int OCLASS_W = 3;
   localparam int TOTAL_W  = 10;

   // register widths
   localparam int NCLS_W = 4;
   localparam int MAXP_W = 10;
   localparam int MAXT_W = 10;
   localparam int RR_W   = 4;
   localparam int PROD_W = PRIO_W + NCLS_W;

   // apb port
   localparam int PADDR_W = 4;
   localparam int PDATA_W = 32;

   // register reset values
   localparam logic [NCLS_W-1:0] NUM_CLASSES_RST  = 4'd8;
   localparam logic [MAXP_W-1:0] MAX_PRIORITY_RST = 10'd255;
   localparam logic [MAXT_W-1:0] MAX_TOTAL_RST    = 10'd512;

   // round-robin pointer value that points before class zero
   localparam logic [RR_W-1:0] RR_BEFORE_FIRST = '1;

   typedef enum logic {
      FUNC_ENQ = 1'b0,
      FUNC_DEQ = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_ENQ   = 2'd0,
      ST_DEQ   = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_NUM_CLASSES  = 2'd0,
      REG_MAX_PRIORITY = 2'd1,
      REG_MAX_TOTAL    = 2'd2,
      REG_NONE         = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

   // configuration as seen by the datapath
   typedef struct packed {
      logic [NCLS_W-1:0] num_classes;
      logic [MAXP_W-1:0] max_priority;
      logic [MAXT_W-1:0] max_total;
      logic [NCLS_W-1:0] eff_classes;
   } cfg_type;

   // captured operation
   typedef struct packed {
      func_type          func;
      logic [PROD_W-1:0] prod;
   } op_type;

   // result of one queue operation
   typedef struct packed {
      status_type          status;
      logic [OCLASS_W-1:0] out_class;
      logic [TOTAL_W-1:0]  total_held;
      logic                departure_ready;
   } res_type;

endpackage

@@ rtl/core/prcq_if.sv @@
// valid/ready channel interfaces for request and response beats
interface prcq_req_if import prcq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [PRIO_W-1:0]   priority_req;
   logic [HANDLE_W-1:0] packet_handle;

   modport source (output valid, func, priority_req, packet_handle, input ready);
   modport sink (input valid, func, priority_req, packet_handle, output ready);
endinterface

interface prcq_rsp_if import prcq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [HANDLE_W-1:0] out_handle;
   logic [OCLASS_W-1:0] out_class;
   logic [TOTAL_W-1:0]  total_held;
   logic                departure_ready;

   modport source (output valid, status, out_handle, out_class, total_held,
                   departure_ready, input ready);
   modport sink (input valid, status, out_handle, out_class, total_held,
                 departure_ready, output ready);
endinterface

@@ rtl/core/prcq_csr.sv @@
// apb configuration registers and effective class count
module prcq_csr import prcq_pkg::*; #(
   parameter int MAX_CLASSES = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready,
   output cfg_type            cfg
);

   logic [NCLS_W-1:0] num_classes_ff;
   logic [MAXP_W-1:0] max_priority_ff;
   logic [MAXT_W-1:0] max_total_ff;
   logic              wr_en;
   reg_idx_type       reg_idx;
   logic [NCLS_W-1:0] eff;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_idx_type'(paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         num_classes_ff  <= NUM_CLASSES_RST;
         max_priority_ff <= MAX_PRIORITY_RST;
         max_total_ff    <= MAX_TOTAL_RST;
      end else if (wr_en) begin
         case (reg_idx)
            REG_NUM_CLASSES:  num_classes_ff  <= pwdata[NCLS_W-1:0];
            REG_MAX_PRIORITY: max_priority_ff <= pwdata[MAXP_W-1:0];
            REG_MAX_TOTAL:    max_total_ff    <= pwdata[MAXT_W-1:0];
            default:          ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_idx)
         REG_NUM_CLASSES:  prdata = PDATA_W'(num_classes_ff);
         REG_MAX_PRIORITY: prdata = PDATA_W'(max_priority_ff);
         REG_MAX_TOTAL:    prdata = PDATA_W'(max_total_ff);
         default:          prdata = '0;
      endcase
   end

   // class count clamped to max priority, to the class slots and to one
   always_comb begin
      eff = num_classes_ff;
      if (MAXP_W'(eff) > max_priority_ff) eff = NCLS_W'(max_priority_ff);
      if (int'(eff) > MAX_CLASSES) eff = NCLS_W'(MAX_CLASSES);
      if (eff == '0) eff = NCLS_W'(1);
   end

   assign cfg.num_classes  = num_classes_ff;
   assign cfg.max_priority = max_priority_ff;
   assign cfg.max_total    = max_total_ff;
   assign cfg.eff_classes  = eff;

endmodule

@@ rtl/core/prcq_store.sv @@
// handle memory: one write or one registered read per cycle
module prcq_store #(
   parameter int AW = 9,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic          rd_en,
   input  logic [AW-1:0] addr,
   input  logic [DW-1:0] wdata,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [2**AW];
   logic [DW-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) mem[addr] <= wdata;
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/prcq_sched.sv @@
// class pick, round-robin scan and per-class head, tail and fill counters
module prcq_sched import prcq_pkg::*; #(
   parameter  int MAX_CLASSES = 8,
   parameter  int CLASS_DEPTH = 64,
   localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1,
   localparam int PW = $clog2(CLASS_DEPTH),
   localparam int AW = CW + PW
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          exec,
   input  op_type        op,
   input  cfg_type       cfg,
   output res_type       res,
   output logic          mem_wr,
   output logic          mem_rd,
   output logic [AW-1:0] mem_addr
);

   localparam int NW = $clog2(CLASS_DEPTH + 1);
   localparam int TW = $clog2(MAX_CLASSES * CLASS_DEPTH + 1);
   localparam int XW = (TW > MAXT_W) ? TW : MAXT_W;

   logic [PW-1:0]   head_ff [MAX_CLASSES];
   logic [PW-1:0]   tail_ff [MAX_CLASSES];
   logic [NW-1:0]   cnt_ff  [MAX_CLASSES];
   logic [TW-1:0]   total_ff;
   logic [RR_W-1:0] rr_ff;

   logic [PW-1:0]    head_in;
   logic [PW-1:0]    tail_in;
   logic [NW-1:0]    cnt_in;
   logic [TW-1:0]    total_in;
   logic [RR_W-1:0]  rr_in;

   logic [NCLS_W-1:0]      e;
   logic [CW-1:0]          pick;
   logic [MAX_CLASSES-1:0] nonempty;
   logic [RR_W-1:0]        start;
   logic                   any_lo;
   logic                   any_hi;
   logic [CW-1:0]          lo_sel;
   logic [CW-1:0]          hi_sel;
   logic [CW-1:0]          cls;
   logic                   full;
   logic                   enq_ok;
   logic                   deq_ok;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      if (p == PW'(CLASS_DEPTH - 1)) return '0;
      return p + 1'b1;
   endfunction

   assign e = cfg.eff_classes;

   // enqueue class: boundaries (i+1)*maxprio that lie below prio*classes
   always_comb begin
      pick = '0;
      for (int i = 0; i < MAX_CLASSES - 1; i++) begin
         if ((i + 1) < int'(e) &&
             (PROD_W'(i + 1) * PROD_W'(cfg.max_priority)) < op.prod)
            pick = CW'(i + 1);
      end
   end

   // round-robin: rotating priority encoder over non-empty classes
   always_comb begin
      start = rr_ff + 1'b1;
      if (start >= e) start = '0;
      any_lo = 1'b0;
      any_hi = 1'b0;
      lo_sel = '0;
      hi_sel = '0;
      for (int j = MAX_CLASSES - 1; j >= 0; j--) begin
         nonempty[j] = (cnt_ff[j] != '0) && (j < int'(e));
         if (nonempty[j]) begin
            any_lo = 1'b1;
            lo_sel = CW'(j);
            if (j >= int'(start)) begin
               any_hi = 1'b1;
               hi_sel = CW'(j);
            end
         end
      end
   end

   // selected class and its counters
   always_comb begin
      if (op.func == FUNC_ENQ) cls = pick;
      else cls = any_hi ? hi_sel : lo_sel;
      full   = (cnt_ff[cls] == NW'(CLASS_DEPTH));
      enq_ok = exec && (op.func == FUNC_ENQ) && !full;
      deq_ok = exec && (op.func == FUNC_DEQ) && any_lo;
      head_in = ptr_inc(head_ff[cls]);
      tail_in = ptr_inc(tail_ff[cls]);
      cnt_in  = enq_ok ? cnt_ff[cls] + 1'b1 : cnt_ff[cls] - 1'b1;
      rr_in   = RR_W'(cls);
      if (enq_ok) total_in = total_ff + 1'b1;
      else if (deq_ok) total_in = total_ff - 1'b1;
      else total_in = total_ff;
   end

   // memory access: write at the tail, read at the head
   assign mem_wr   = enq_ok;
   assign mem_rd   = deq_ok;
   assign mem_addr = (op.func == FUNC_ENQ) ? {cls, tail_ff[cls]} : {cls, head_ff[cls]};

   // result of this operation
   always_comb begin
      if (op.func == FUNC_ENQ) begin
         res.status    = full ? ST_FULL : ST_ENQ;
         res.out_class = OCLASS_W'(cls);
      end else if (any_lo) begin
         res.status    = ST_DEQ;
         res.out_class = OCLASS_W'(cls);
      end else begin
         res.status    = ST_EMPTY;
         res.out_class = '0;
      end
      res.total_held      = TOTAL_W'(total_in);
      res.departure_ready = (total_in != '0) && (XW'(total_in) < XW'(cfg.max_total));
   end

   // queue state update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_CLASSES; k++) begin
            head_ff[k] <= '0;
            tail_ff[k] <= '0;
            cnt_ff[k]  <= '0;
         end
         total_ff <= '0;
         rr_ff    <= RR_BEFORE_FIRST;
      end else begin
         if (enq_ok) begin
            tail_ff[cls] <= tail_in;
            cnt_ff[cls]  <= cnt_in;
         end
         if (deq_ok) begin
            head_ff[cls] <= head_in;
            cnt_ff[cls]  <= cnt_in;
            rr_ff        <= rr_in;
         end
         total_ff <= total_in;
      end
   end

endmodule

@@ rtl/core/priority_class_round_robin_queue_core.sv @@
// top level of the priority class round-robin queue
//
//  channel   dir  handshake          beat
//  req_ch    in   valid/ready        func, priority_req, packet_handle
//  rsp_ch    out  valid/ready        status, out_handle, out_class, total_held,
//                                    departure_ready
//  apb       in   psel/penable       num_classes, max_priority, max_total
//
// an item is handled in two steps: capture in FSM_IDLE, then FSM_EXEC, in which
// the class is chosen, the per-class counters update and the handle memory is
// written or read; the beat then waits in res_ff until the response register is
// free; that register takes the handle from the memory's registered read port, and
// the next item can be taken at the edge that loads the response register
// reset is synchronous; there is no clearing pass, since a handle is read only
// after it was written
// a stalled response holds back the next request only while a result also waits
module priority_class_round_robin_queue_core import prcq_pkg::*; #(
   parameter int MAX_CLASSES = 8,
   parameter int CLASS_DEPTH = 64,
   parameter int HANDLE_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   prcq_req_if.sink           req_ch,
   prcq_rsp_if.source         rsp_ch,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   localparam int CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int PW = $clog2(CLASS_DEPTH);
   localparam int AW = CW + PW;
   localparam int SW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

   cfg_type   cfg;
   fsm_type   state_ff, state_in;
   op_type    op_ff, op_in;
   logic [SW-1:0] handle_ff;
   res_type   res, res_ff;
   logic      from_mem_ff;
   logic      pend_ff, pend_in;
   logic      out_valid_ff, out_valid_in;
   res_type   out_res_ff;
   logic [HANDLE_W-1:0] out_handle_ff, out_handle_in;

   logic          accept;
   logic          exec;
   logic          out_free;
   logic          move;
   logic          mem_wr;
   logic          mem_rd;
   logic [AW-1:0] mem_addr;
   logic [SW-1:0] mem_rdata;

   prcq_csr #(
      .MAX_CLASSES (MAX_CLASSES)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   prcq_sched #(
      .MAX_CLASSES (MAX_CLASSES),
      .CLASS_DEPTH (CLASS_DEPTH)
   ) u_sched (
      .clock    (clock),
      .reset    (reset),
      .exec     (exec),
      .op       (op_ff),
      .cfg      (cfg),
      .res      (res),
      .mem_wr   (mem_wr),
      .mem_rd   (mem_rd),
      .mem_addr (mem_addr)
   );

   prcq_store #(
      .AW (AW),
      .DW (SW)
   ) u_store (
      .clock (clock),
      .wr_en (mem_wr),
      .rd_en (mem_rd),
      .addr  (mem_addr),
      .wdata (handle_ff),
      .rdata (mem_rdata)
   );

   // handshake
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign move         = pend_ff && out_free;
   assign req_ch.ready = (state_ff == FSM_IDLE) && (!pend_ff || out_free);
   assign accept       = req_ch.valid && req_ch.ready;
   assign exec         = (state_ff == FSM_EXEC);

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_EXEC;
         FSM_EXEC: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   // operation capture, class spacing product formed here
   always_comb begin
      op_in.func = func_type'(req_ch.func);
      op_in.prod = PROD_W'(req_ch.priority_req) * PROD_W'(cfg.eff_classes);
   end

   // pending result and output register
   always_comb begin
      pend_in = pend_ff;
      if (exec) pend_in = 1'b1;
      else if (move) pend_in = 1'b0;
      out_valid_in = out_valid_ff;
      if (move) out_valid_in = 1'b1;
      else if (rsp_ch.ready) out_valid_in = 1'b0;
      out_handle_in = from_mem_ff ? HANDLE_W'(mem_rdata) : '0;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= op_in;
         handle_ff <= req_ch.packet_handle[SW-1:0];
      end
      if (exec) begin
         res_ff      <= res;
         from_mem_ff <= mem_rd;
      end
      if (move) begin
         out_res_ff    <= res_ff;
         out_handle_ff <= out_handle_in;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.status          = out_res_ff.status;
   assign rsp_ch.out_handle      = out_handle_ff;
   assign rsp_ch.out_class       = out_res_ff.out_class;
   assign rsp_ch.total_held      = out_res_ff.total_held;
   assign rsp_ch.departure_ready = out_res_ff.departure_ready;

endmodule

@@ rtl/core/prcq_checker.sv @@
// port-level checks of the queue core, bound to the top level
module prcq_checker import prcq_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [STATUS_W-1:0] rsp_status,
   input logic [HANDLE_W-1:0] rsp_out_handle,
   input logic [OCLASS_W-1:0] rsp_out_class,
   input logic [TOTAL_W-1:0]  rsp_total_held,
   input logic                rsp_departure_ready
);

   logic req_beat;
   assign req_beat = req_valid && req_ready;

   // a response beat stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response beat withdrawn before taken");

   // no request beat right after another
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_beat)
      else $error("request beats on consecutive cycles");

   // a response raised from an idle output register must match an earlier request beat
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_beat, 3))
      else $error("response without matching request");

   // only a dequeue carries a handle, and an empty dequeue names class zero
   a_handle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DEQ |->
         rsp_out_handle == '0 && (rsp_status != ST_EMPTY || rsp_out_class == '0))
      else $error("handle or class set on non-dequeue response");

   // departure ready needs something held
   a_ready_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_departure_ready |-> rsp_total_held != '0)
      else $error("departure ready with empty queue");

endmodule

bind priority_class_round_robin_queue_core prcq_checker u_prcq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_status          (rsp_ch.status),
   .rsp_out_handle      (rsp_ch.out_handle),
   .rsp_out_class       (rsp_ch.out_class),
   .rsp_total_held      (rsp_ch.total_held),
   .rsp_departure_ready (rsp_ch.departure_ready)
);

@@ test/priority_class_round_robin_queue_core_tb.sv @@
// testbench for the priority class round-robin queue core: directed rows, random phases, predictor
module priority_class_round_robin_queue_core_tb;
   import prcq_pkg::*;

   localparam int MAX_CLASSES = 8;
   localparam int CLASS_DEPTH = 64;
   localparam int HANDLE_BITS = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int HOLD_CYCLES = 200;

   // one response beat as the checker sees it
   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] out_handle;
      logic [OCLASS_W-1:0] out_class;
      logic [TOTAL_W-1:0]  total_held;
      logic                departure_ready;
   } rsp_beat_type;

   // one directed request, with a hand-written response where it is obvious
   typedef struct packed {
      func_type            func;
      logic [PRIO_W-1:0]   prio;
      logic [HANDLE_W-1:0] handle;
      logic                typed;
      rsp_beat_type        want;
   } stim_row_type;

   localparam rsp_beat_type UNTYPED = '{ST_ENQ, 16'h0000, 3'd0, 10'd0, 1'b0};

   logic               clock = 1'b0;
   logic               reset;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [PDATA_W-1:0] pwdata;
   logic [PDATA_W-1:0] prdata;
   logic               pready;

   prcq_req_if req_ch ();
   prcq_rsp_if rsp_ch ();

   priority_class_round_robin_queue_core #(
      .MAX_CLASSES(MAX_CLASSES),
      .CLASS_DEPTH(CLASS_DEPTH),
      .HANDLE_BITS(HANDLE_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: per-class handle queues, occupancy, pointer, registers
   logic [HANDLE_W-1:0] class_slots [MAX_CLASSES][$];
   int                  held_total = 0;
   logic [RR_W-1:0]     rr_ptr = RR_BEFORE_FIRST;
   logic [NCLS_W-1:0]   cfg_num_classes = NUM_CLASSES_RST;
   logic [MAXP_W-1:0]   cfg_max_priority = MAX_PRIORITY_RST;
   logic [MAXT_W-1:0]   cfg_max_total = MAX_TOTAL_RST;

   rsp_beat_type awaited_beats [$];
   int        mismatches = 0;
   int unsigned cycle_count = 0;

   // knobs shared between the sender and the receiver
   bit sender_gaps = 1'b1;
   bit sink_stalls = 1'b1;
   bit hold_request = 1'b0;

   stim_row_type directed_rows [19] = '{
      // empty after reset
      '{FUNC_DEQ, 10'h3ff, 16'hdead, 1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 10'd0, 1'b0}},
      // lowest priority lands in class 0, highest past the last boundary in the top class
      '{FUNC_ENQ, 10'h000, 16'hffff, 1'b1, '{ST_ENQ, 16'h0000, 3'd0, 10'd1, 1'b1}},
      '{FUNC_ENQ, 10'h3ff, 16'h0000, 1'b1, '{ST_ENQ, 16'h0000, 3'd7, 10'd2, 1'b1}},
      '{FUNC_ENQ, 10'd255, 16'ha5a5, 1'b0, UNTYPED},
      '{FUNC_ENQ, 10'd32,  16'h5a5a, 1'b0, UNTYPED},
      '{FUNC_ENQ, 10'd31,  16'h1234, 1'b0, UNTYPED},
      '{FUNC_ENQ, 10'd128, 16'h0001, 1'b0, UNTYPED},
      // first dequeue starts at class 0
      '{FUNC_DEQ, 10'h155, 16'h2aaa, 1'b1, '{ST_DEQ, 16'hffff, 3'd0, 10'd5, 1'b1}},
      '{FUNC_DEQ, 10'h2aa, 16'h5555, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h000, 16'h0000, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h3ff, 16'hffff, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h001, 16'h8000, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h200, 16'h7fff, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h100, 16'h0f0f, 1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 10'd0, 1'b0}},
      // pointer wraps back onto the top class
      '{FUNC_ENQ, 10'h3ff, 16'h8000, 1'b0, UNTYPED},
      '{FUNC_ENQ, 10'd512, 16'h7fff, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h0ff, 16'hf0f0, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h300, 16'h00ff, 1'b0, UNTYPED},
      '{FUNC_DEQ, 10'h0aa, 16'hff00, 1'b1, '{ST_EMPTY, 16'h0000, 3'd0, 10'd0, 1'b0}}
   };

   // predicted response of one accepted request, updating the queue state
   function automatic rsp_beat_type serve_queue_op(input func_type f,
                                                   input logic [PRIO_W-1:0] prio,
                                                   input logic [HANDLE_W-1:0] handle);
      rsp_beat_type    beat;
      int              eff;
      int              cls;
      bit              found;
      logic [RR_W-1:0] start;
      beat = UNTYPED;
      eff = int'(cfg_num_classes);
      if (eff > int'(cfg_max_priority)) eff = int'(cfg_max_priority);
      if (eff > MAX_CLASSES) eff = MAX_CLASSES;
      if (eff < 1) eff = 1;
      if (f == FUNC_ENQ) begin
         // count the boundaries that lie below the priority
         cls = 0;
         while (cls + 1 < eff && (cls + 1) * int'(cfg_max_priority) < int'(prio) * eff)
            cls++;
         beat.out_class = OCLASS_W'(cls);
         if (class_slots[cls].size() >= CLASS_DEPTH) begin
            beat.status = ST_FULL;
         end else begin
            class_slots[cls].insert(class_slots[cls].size(), handle);
            held_total++;
            beat.status = ST_ENQ;
         end
      end else begin
         // next non-empty class after the pointer, wrapping at the class count
         start = rr_ptr + 1'b1;
         cls = int'(start);
         if (cls >= eff) cls = 0;
         found = 1'b0;
         for (int n = 0; n < eff && !found; n++) begin
            if (class_slots[cls].size() != 0) begin
               found = 1'b1;
            end else begin
               cls++;
               if (cls >= eff) cls = 0;
            end
         end
         if (found && held_total > 0) begin
            beat.out_handle = class_slots[cls][0];
            class_slots[cls].delete(0);
            held_total--;
            rr_ptr = RR_W'(cls);
            beat.out_class = OCLASS_W'(cls);
            beat.status = ST_DEQ;
         end else begin
            beat.status = ST_EMPTY;
         end
      end
      beat.total_held = TOTAL_W'(held_total);
      beat.departure_ready = held_total > 0 && held_total < int'(cfg_max_total);
      return beat;
   endfunction

   // offer one request beat and hold it until accepted
   task automatic send_item(input func_type f, input logic [PRIO_W-1:0] prio,
                            input logic [HANDLE_W-1:0] handle, input logic typed,
                            input rsp_beat_type want);
      rsp_beat_type predicted;
      @(negedge clock);
      req_ch.valid <= 1'b1;
      req_ch.func <= f;
      req_ch.priority_req <= prio;
      req_ch.packet_handle <= handle;
      do @(posedge clock); while (!req_ch.ready);
      predicted = serve_queue_op(f, prio, handle);
      awaited_beats.insert(awaited_beats.size(), typed ? want : predicted);
   endtask

   // random idle gap on the request side, mostly short
   task automatic sender_pause();
      int gap;
      int pick;
      if (!sender_gaps) return;
      pick = $urandom_range(0, 9);
      if (pick < 6) gap = 0;
      else if (pick < 9) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 30);
      if (gap == 0) return;
      @(negedge clock);
      req_ch.valid <= 1'b0;
      req_ch.func <= 1'($urandom_range(0, 1));
      req_ch.priority_req <= PRIO_W'($urandom);
      req_ch.packet_handle <= HANDLE_W'($urandom);
      repeat (gap - 1) @(negedge clock);
   endtask

   // drop valid and wait for every outstanding response
   task automatic settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_beats.size() != 0) @(posedge clock);
   endtask

   // apb write: setup then access, register taken with pready
   task automatic write_reg(input reg_idx_type idx, input logic [PDATA_W-1:0] value);
      settle();
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         REG_NUM_CLASSES:  cfg_num_classes = value[NCLS_W-1:0];
         REG_MAX_PRIORITY: cfg_max_priority = value[MAXP_W-1:0];
         REG_MAX_TOTAL:    cfg_max_total = value[MAXT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   task automatic configure(input logic [PDATA_W-1:0] classes, input logic [PDATA_W-1:0] maxp,
                            input logic [PDATA_W-1:0] maxt);
      write_reg(REG_NUM_CLASSES, classes);
      write_reg(REG_MAX_PRIORITY, maxp);
      write_reg(REG_MAX_TOTAL, maxt);
   endtask

   // priorities biased toward the range up to max_priority, where the class boundaries lie, and the extremes
   function automatic logic [PRIO_W-1:0] random_priority();
      int top;
      logic [PRIO_W-1:0] prio;
      top = int'(cfg_max_priority) + 2;
      if (top > 1023) top = 1023;
      case ($urandom_range(0, 3))
         0: prio = PRIO_W'($urandom_range(0, top));
         1: prio = $urandom_range(0, 1) ? '1 : '0;
         default: prio = PRIO_W'($urandom);
      endcase
      return prio;
   endfunction

   // random mix of enqueues and dequeues under the current registers
   task automatic run_phase(input int count, input int enq_pct);
      func_type            f;
      logic [HANDLE_W-1:0] handle;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
         if ($urandom_range(0, 15) == 0) handle = $urandom_range(0, 1) ? '1 : '0;
         else handle = HANDLE_W'($urandom);
         send_item(f, random_priority(), handle, 1'b0, UNTYPED);
         sender_pause();
      end
   endtask

   // stimulus
   initial begin : stimulus
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_ENQ;
      req_ch.priority_req = '0;
      req_ch.packet_handle = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed rows under reset settings
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].func, directed_rows[i].prio, directed_rows[i].handle,
                   directed_rows[i].typed, directed_rows[i].want);
         sender_pause();
      end

      run_phase(50, 50);

      // one class only: fills up and drops
      configure(32'd1, 32'd999, 32'd1);
      run_phase(110, 92);

      // class count clamped to the maximum, widest registers; drains the full class
      configure(32'd15, 32'd1023, 32'd1023);
      run_phase(70, 25);
      write_reg(REG_NONE, 32'hffff_ffff);

      // class count clamped by max_priority, upper classes stranded
      configure(32'd8, 32'd2, 32'd20);
      run_phase(50, 55);

      // zero registers, back to back with no idling
      sender_gaps = 1'b0;
      sink_stalls = 1'b0;
      configure(32'd0, 32'd0, 32'd0);
      run_phase(40, 50);

      // receiver holds off while requests keep coming
      configure(32'd5, 32'd700, 32'd300);
      hold_request = 1'b1;
      run_phase(60, 60);

      sender_gaps = 1'b1;
      sink_stalls = 1'b1;
      configure(32'd8, 32'd1, 32'd512);
      run_phase(40, 45);

      settle();
      repeat (10) @(posedge clock);
      if (mismatches == 0) begin
         $display("priority_class_round_robin_queue_core: match");
      end else begin
         $display("priority_class_round_robin_queue_core: mismatch");
      end
      $finish;
   end

   // response ready: runs of ready, short and long stalls, one long hold on request
   initial begin : rsp_sink
      int run_len;
      run_len = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            run_len = 0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (run_len > 0) begin
            run_len--;
         end else if (!sink_stalls || $urandom_range(0, 2) != 0) begin
            rsp_ch.ready <= 1'b1;
            run_len = $urandom_range(0, 30);
         end else begin
            rsp_ch.ready <= 1'b0;
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 2);
         end
      end
   end

   task automatic check_field(input string name, input logic [HANDLE_W-1:0] want,
                              input logic [HANDLE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // compare each accepted response beat with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_beat_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_beats.size() == 0) begin
            $error("response beat with no request outstanding");
            mismatches++;
         end else begin
            want = awaited_beats[0];
            awaited_beats.delete(0);
            check_field("status", HANDLE_W'(want.status), HANDLE_W'(rsp_ch.status));
            check_field("out_handle", want.out_handle, rsp_ch.out_handle);
            check_field("out_class", HANDLE_W'(want.out_class), HANDLE_W'(rsp_ch.out_class));
            check_field("total_held", HANDLE_W'(want.total_held),
                        HANDLE_W'(rsp_ch.total_held));
            check_field("departure_ready", HANDLE_W'(want.departure_ready),
                        HANDLE_W'(rsp_ch.departure_ready));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("priority_class_round_robin_queue_core: mismatch");
         $finish;
      end
   end

endmodule
